@@ rtl/smc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite mask collision package
// Shared constants, register map and the mask row address helper.
// ----------------------------------------------------------------------------
package smc_pkg;

  // Sprite geometry and grid size.
  localparam int SPRITE_PIXELS = 16;
  localparam int GRID_SIDE     = 16;

  // Row index width within one sprite mask.
  localparam int ROW_W = $clog2(SPRITE_PIXELS);
  // Signed width of a vertical offset plus a row index.
  localparam int OFF_W = ROW_W + 2;

  // Mask memory: one entry per mask row of every sprite in the grid.
  localparam int MASK_DEPTH = GRID_SIDE * GRID_SIDE * SPRITE_PIXELS;
  localparam int ADDR_W     = $clog2(MASK_DEPTH);

  // Alpha and threshold register.
  localparam int                ALPHA_W      = 8;
  localparam logic [ALPHA_W-1:0] THRESH_RESET = 8'd128;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_ALPHA_THRESHOLD = 1'b0;

  // Item actions.
  localparam logic ACTION_LOAD  = 1'b0;
  localparam logic ACTION_QUERY = 1'b1;

  // Memory address of one mask row of the sprite in a given grid cell.
  function automatic logic [ADDR_W-1:0] row_addr(input logic [7:0]       cell_row,
                                                 input logic [7:0]       cell_col,
                                                 input logic [ROW_W-1:0] r);
    return ADDR_W'((int'(cell_row) * GRID_SIDE + int'(cell_col)) * SPRITE_PIXELS
                   + int'(r));
  endfunction

endpackage

@@ rtl/sprite_mask_collision.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite mask collision
// Pixel-exact collision test between two sprites of a mask sheet.
//
//   Channel   Handshake              Payload
//   input     in_valid_i/in_ready_o  action, pixel_x/y, alpha, first_*, second_*
//   output    out_valid_o/out_ready_i hit (one transaction per query)
//   config    psel/penable/pwrite    paddr, pwdata, prdata (alpha threshold)
//
// After reset the mask memory is cleared one row a cycle, with in_ready_o low.
// A load of a solid pixel on the grid reads the mask row, then writes it back
// with the bit set; other loads are dropped. A query runs the check, scan,
// drain and done states (check and done when rejected early); the scan reads
// the 16 row pairs through the two memory read ports one pair a cycle. A
// finished result waits in the output register; the next item is accepted
// meanwhile, and a query only stalls at its end while that register is full.
// ----------------------------------------------------------------------------
module sprite_mask_collision (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [smc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [smc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [smc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  // Input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            action_i,
  input  logic [7:0]                      pixel_x_i,
  input  logic [7:0]                      pixel_y_i,
  input  logic [7:0]                      alpha_i,
  input  logic signed [15:0]              first_x_i,
  input  logic signed [15:0]              first_y_i,
  input  logic [3:0]                      first_col_i,
  input  logic [3:0]                      first_row_i,
  input  logic signed [15:0]              second_x_i,
  input  logic signed [15:0]              second_y_i,
  input  logic [3:0]                      second_col_i,
  input  logic [3:0]                      second_row_i,
  // Output channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            hit_o
);
  import smc_pkg::*;

  logic [ALPHA_W-1:0]       alpha_threshold;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [SPRITE_PIXELS-1:0] ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr_a;
  logic [ADDR_W-1:0]        ram_raddr_b;
  logic [SPRITE_PIXELS-1:0] ram_rdata_a;
  logic [SPRITE_PIXELS-1:0] ram_rdata_b;

  // Threshold register.
  smc_apb u_apb (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .alpha_threshold_o (alpha_threshold)
  );

  // Load and query sequencer.
  smc_engine u_engine (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .alpha_threshold_i (alpha_threshold),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .pixel_x_i         (pixel_x_i),
    .pixel_y_i         (pixel_y_i),
    .alpha_i           (alpha_i),
    .first_x_i         (first_x_i),
    .first_y_i         (first_y_i),
    .first_col_i       (first_col_i),
    .first_row_i       (first_row_i),
    .second_x_i        (second_x_i),
    .second_y_i        (second_y_i),
    .second_col_i      (second_col_i),
    .second_row_i      (second_row_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .hit_o             (hit_o),
    .ram_we_o          (ram_we),
    .ram_waddr_o       (ram_waddr),
    .ram_wdata_o       (ram_wdata),
    .ram_raddr_a_o     (ram_raddr_a),
    .ram_raddr_b_o     (ram_raddr_b),
    .ram_rdata_a_i     (ram_rdata_a),
    .ram_rdata_b_i     (ram_rdata_b)
  );

  // Mask memory: one row of sprite pixels per entry.
  smc_ram #(
    .WIDTH (SPRITE_PIXELS),
    .DEPTH (MASK_DEPTH)
  ) u_mask_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

endmodule

@@ rtl/smc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, each read registered.
// ----------------------------------------------------------------------------
module smc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Storage write and registered reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ rtl/smc_apb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite mask collision configuration port
// APB-style register file holding the alpha threshold.
// ----------------------------------------------------------------------------
module smc_apb (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [smc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [smc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [smc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [smc_pkg::ALPHA_W-1:0]     alpha_threshold_o
);
  import smc_pkg::*;

  logic [ALPHA_W-1:0] thresh_q;
  logic [ALPHA_W-1:0] thresh_d;
  logic               wr_en;
  logic               sel_thresh;

  // The port never inserts wait states.
  assign pready = 1'b1;

  // Word decode and write strobe.
  assign sel_thresh = (paddr[APB_ADDR_W-1:2] == REG_ALPHA_THRESHOLD);
  assign wr_en      = psel && penable && pwrite && pready;

  always_comb begin
    thresh_d = thresh_q;
    if (wr_en && sel_thresh) begin
      thresh_d = pwdata[ALPHA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else begin
      thresh_q <= thresh_d;
    end
  end

  // Read data for the selected register; unmapped words read as zero.
  assign prdata            = sel_thresh ? APB_DATA_W'(thresh_q) : '0;
  assign alpha_threshold_o = thresh_q;

endmodule

@@ rtl/smc_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite mask collision engine
// Sequencer that clears the mask memory, sets mask bits by read-modify-write
// and scans row pairs for a collision query.
// ----------------------------------------------------------------------------
module smc_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [smc_pkg::ALPHA_W-1:0]  alpha_threshold_i,
  // Input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         action_i,
  input  logic [7:0]                   pixel_x_i,
  input  logic [7:0]                   pixel_y_i,
  input  logic [7:0]                   alpha_i,
  input  logic signed [15:0]           first_x_i,
  input  logic signed [15:0]           first_y_i,
  input  logic [3:0]                   first_col_i,
  input  logic [3:0]                   first_row_i,
  input  logic signed [15:0]           second_x_i,
  input  logic signed [15:0]           second_y_i,
  input  logic [3:0]                   second_col_i,
  input  logic [3:0]                   second_row_i,
  // Output channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  // Mask memory
  output logic                              ram_we_o,
  output logic [smc_pkg::ADDR_W-1:0]        ram_waddr_o,
  output logic [smc_pkg::SPRITE_PIXELS-1:0] ram_wdata_o,
  output logic [smc_pkg::ADDR_W-1:0]        ram_raddr_a_o,
  output logic [smc_pkg::ADDR_W-1:0]        ram_raddr_b_o,
  input  logic [smc_pkg::SPRITE_PIXELS-1:0] ram_rdata_a_i,
  input  logic [smc_pkg::SPRITE_PIXELS-1:0] ram_rdata_b_i
);
  import smc_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_LOAD_WR = 3'd2;
  localparam logic [2:0] ST_Q_CHECK = 3'd3;
  localparam logic [2:0] ST_Q_SCAN  = 3'd4;
  localparam logic [2:0] ST_Q_DRAIN = 3'd5;
  localparam logic [2:0] ST_Q_DONE  = 3'd6;

  localparam logic signed [16:0] SP_POS   = 17'(SPRITE_PIXELS);
  localparam logic signed [16:0] SP_NEG   = -SP_POS;
  localparam logic [ROW_W-1:0]   ROW_LAST = ROW_W'(SPRITE_PIXELS - 1);
  localparam logic [ADDR_W-1:0]  CLR_LAST = ADDR_W'(MASK_DEPTH - 1);

  logic [2:0]               state_q, state_d;
  logic [ADDR_W-1:0]        clr_cnt_q, clr_cnt_d;
  logic [ADDR_W-1:0]        ld_addr_q, ld_addr_d;
  logic [SPRITE_PIXELS-1:0] ld_bit_q, ld_bit_d;
  logic signed [16:0]       dx_q, dx_d;
  logic signed [16:0]       dy_q, dy_d;
  logic [3:0]               f_col_q, f_col_d;
  logic [3:0]               f_row_q, f_row_d;
  logic [3:0]               s_col_q, s_col_d;
  logic [3:0]               s_row_q, s_row_d;
  logic [ROW_W-1:0]         row_q, row_d;
  logic                     dx_neg_q, dx_neg_d;
  logic [ROW_W-1:0]         dx_mag_q, dx_mag_d;
  logic signed [OFF_W-1:0]  dy_off_q, dy_off_d;
  logic                     cmp_valid_q, cmp_valid_d;
  logic                     hit_acc_q, hit_acc_d;
  logic                     out_valid_q, out_valid_d;
  logic                     hit_q, hit_d;

  logic                     in_accept;
  logic [7:0]               ld_cell_x, ld_cell_y;
  logic [7:0]               ld_pix_x, ld_pix_y;
  logic                     ld_ok;
  logic [ADDR_W-1:0]        ld_addr;
  logic [SPRITE_PIXELS-1:0] ld_bit;
  logic                     q_reject;
  logic signed [OFF_W-1:0]  first_row_idx;
  logic                     first_row_ok;
  logic [SPRITE_PIXELS-1:0] first_shifted;
  logic                     pair_hit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // Load decode: sprite cell, pixel within the sprite and the bit to set.
  assign ld_cell_x = 8'(pixel_x_i / SPRITE_PIXELS);
  assign ld_cell_y = 8'(pixel_y_i / SPRITE_PIXELS);
  assign ld_pix_x  = 8'(pixel_x_i % SPRITE_PIXELS);
  assign ld_pix_y  = 8'(pixel_y_i % SPRITE_PIXELS);
  assign ld_ok     = (alpha_i >= alpha_threshold_i) && (int'(ld_cell_x) < GRID_SIDE)
                     && (int'(ld_cell_y) < GRID_SIDE);
  assign ld_addr   = row_addr(ld_cell_y, ld_cell_x, ld_pix_y[ROW_W-1:0]);
  assign ld_bit    = {{(SPRITE_PIXELS-1){1'b0}}, 1'b1}
                     << (ROW_W'(SPRITE_PIXELS - 1) - ld_pix_x[ROW_W-1:0]);

  // Early rejection: boxes apart, wide horizontal offset or a cell off the grid.
  assign q_reject = (dy_q < SP_NEG) || (dy_q > SP_POS) || (dx_q <= SP_NEG)
                    || (dx_q >= SP_POS)
                    || (int'(f_col_q) >= GRID_SIDE) || (int'(f_row_q) >= GRID_SIDE)
                    || (int'(s_col_q) >= GRID_SIDE) || (int'(s_row_q) >= GRID_SIDE);

  // Row of the first sprite that lines up with row row_q of the second.
  assign first_row_idx = dy_off_q + $signed({2'b00, row_q});
  assign first_row_ok  = (first_row_idx >= 0)
                         && (first_row_idx < OFF_W'(SPRITE_PIXELS));

  // Row pair compare on the registered memory data.
  assign first_shifted = dx_neg_q ? (ram_rdata_b_i >> dx_mag_q)
                                  : (ram_rdata_b_i << dx_mag_q);
  assign pair_hit      = |(ram_rdata_a_i & first_shifted);

  // Memory ports.
  always_comb begin
    ram_we_o      = 1'b0;
    ram_waddr_o   = ld_addr_q;
    ram_wdata_o   = ram_rdata_a_i | ld_bit_q;
    ram_raddr_a_o = ld_addr;
    ram_raddr_b_o = row_addr(8'(f_row_q), 8'(f_col_q), first_row_idx[ROW_W-1:0]);
    unique case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_cnt_q;
        ram_wdata_o = '0;
      end
      ST_LOAD_WR: begin
        ram_we_o = 1'b1;
      end
      ST_Q_SCAN: begin
        ram_raddr_a_o = row_addr(8'(s_row_q), 8'(s_col_q), row_q);
      end
      default: begin
        ram_we_o = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    ld_addr_d   = ld_addr_q;
    ld_bit_d    = ld_bit_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    f_col_d     = f_col_q;
    f_row_d     = f_row_q;
    s_col_d     = s_col_q;
    s_row_d     = s_row_q;
    row_d       = row_q;
    dx_neg_d    = dx_neg_q;
    dx_mag_d    = dx_mag_q;
    dy_off_d    = dy_off_q;
    cmp_valid_d = 1'b0;
    hit_acc_d   = hit_acc_q;
    out_valid_d = out_valid_q;
    hit_d       = hit_q;

    // The output register empties when its transaction completes.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Accumulate the row pair read in the previous cycle.
    if (cmp_valid_q && pair_hit) begin
      hit_acc_d = 1'b1;
    end

    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (action_i == ACTION_QUERY) begin
            dx_d    = {second_x_i[15], second_x_i} - {first_x_i[15], first_x_i};
            dy_d    = {second_y_i[15], second_y_i} - {first_y_i[15], first_y_i};
            f_col_d = first_col_i;
            f_row_d = first_row_i;
            s_col_d = second_col_i;
            s_row_d = second_row_i;
            state_d = ST_Q_CHECK;
          end else if (ld_ok) begin
            ld_addr_d = ld_addr;
            ld_bit_d  = ld_bit;
            state_d   = ST_LOAD_WR;
          end
        end
      end
      ST_LOAD_WR: begin
        state_d = ST_IDLE;
      end
      ST_Q_CHECK: begin
        dx_neg_d  = dx_q[16];
        dx_mag_d  = dx_q[16] ? ROW_W'(-dx_q) : ROW_W'(dx_q);
        dy_off_d  = OFF_W'(dy_q);
        row_d     = '0;
        hit_acc_d = 1'b0;
        state_d   = q_reject ? ST_Q_DONE : ST_Q_SCAN;
      end
      ST_Q_SCAN: begin
        cmp_valid_d = first_row_ok;
        row_d       = row_q + 1'b1;
        if (row_q == ROW_LAST) begin
          state_d = ST_Q_DRAIN;
        end
      end
      ST_Q_DRAIN: begin
        state_d = ST_Q_DONE;
      end
      ST_Q_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          hit_d       = hit_acc_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      cmp_valid_q <= cmp_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    ld_addr_q <= ld_addr_d;
    ld_bit_q  <= ld_bit_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    f_col_q   <= f_col_d;
    f_row_q   <= f_row_d;
    s_col_q   <= s_col_d;
    s_row_q   <= s_row_d;
    row_q     <= row_d;
    dx_neg_q  <= dx_neg_d;
    dx_mag_q  <= dx_mag_d;
    dy_off_q  <= dy_off_d;
    hit_acc_q <= hit_acc_d;
    hit_q     <= hit_d;
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite mask collision testbench
// Loads sheet pixels into the sprite masks and runs collision queries through
// the valid/ready channels, checking every hit against a local prediction of
// the mask store and the alpha threshold. It covers directed corner cases, random
// phases with varying threshold and idling, and a long output stall.
// ----------------------------------------------------------------------------
module tb;
  import smc_pkg::*;

  localparam int                    STALL_LIMIT  = 20000;
  localparam int                    HOLD_CYCLES  = 400;
  localparam int                    SETTLE       = 40;
  localparam logic [APB_ADDR_W-1:0] THRESH_ADDR  = {REG_ALPHA_THRESHOLD, 2'b00};

  // One input transaction with every field of the input channel.
  typedef struct {
    logic               action;
    logic [7:0]         pixel_x;
    logic [7:0]         pixel_y;
    logic [7:0]         alpha;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic [3:0]         first_col;
    logic [3:0]         first_row;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic [3:0]         second_col;
    logic [3:0]         second_row;
  } sprite_op_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic               action_i     = ACTION_LOAD;
  logic [7:0]         pixel_x_i    = '0;
  logic [7:0]         pixel_y_i    = '0;
  logic [7:0]         alpha_i      = '0;
  logic signed [15:0] first_x_i    = '0;
  logic signed [15:0] first_y_i    = '0;
  logic [3:0]         first_col_i  = '0;
  logic [3:0]         first_row_i  = '0;
  logic signed [15:0] second_x_i   = '0;
  logic signed [15:0] second_y_i   = '0;
  logic [3:0]         second_col_i = '0;
  logic [3:0]         second_row_i = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic               hit_o;

  // Predicted block state: mask rows indexed by grid row, grid column, row.
  logic [SPRITE_PIXELS-1:0] sheet_mask [GRID_SIDE][GRID_SIDE][SPRITE_PIXELS];
  logic [ALPHA_W-1:0]       solid_threshold = THRESH_RESET;

  // Hits still owed by the block, oldest first.
  logic hit_q [$];

  int fail_count   = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int stall_count  = 0;

  // Receiver hold-off request and its bookkeeping in the receiver process.
  logic hold_tgl  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  // Grid cells that most random loads and queries are aimed at.
  logic [3:0] busy_col [4];
  logic [3:0] busy_row [4];

  sprite_mask_collision u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .alpha_i      (alpha_i),
    .first_x_i    (first_x_i),
    .first_y_i    (first_y_i),
    .first_col_i  (first_col_i),
    .first_row_i  (first_row_i),
    .second_x_i   (second_x_i),
    .second_y_i   (second_y_i),
    .second_col_i (second_col_i),
    .second_row_i (second_row_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o)
  );

  always #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // A solid pixel sets its bit in the mask of the sprite cell it falls in.
  function automatic void apply_load(sprite_op_t op);
    int cx, cy, px, py;
    cx = int'(op.pixel_x) / SPRITE_PIXELS;
    cy = int'(op.pixel_y) / SPRITE_PIXELS;
    px = int'(op.pixel_x) % SPRITE_PIXELS;
    py = int'(op.pixel_y) % SPRITE_PIXELS;
    if (op.alpha >= solid_threshold && cx < GRID_SIDE && cy < GRID_SIDE) begin
      sheet_mask[cy][cx][py][SPRITE_PIXELS-1-px] = 1'b1;
    end
  endfunction

  function automatic logic [SPRITE_PIXELS-1:0] mask_row(int col, int row, int r);
    if (col >= GRID_SIDE || row >= GRID_SIDE || r < 0 || r >= SPRITE_PIXELS) begin
      return '0;
    end
    return sheet_mask[row][col][r];
  endfunction

  // Box rejection, then the overlapping rows ANDed with the horizontal shift.
  function automatic logic collision_hit(sprite_op_t op);
    int          fx, fy, sx, sy, dx, dy, r;
    logic [31:0] first_bits;
    logic [31:0] second_bits;
    fx = op.first_x;
    fy = op.first_y;
    sx = op.second_x;
    sy = op.second_y;
    if (sx + SPRITE_PIXELS < fx || sx > fx + SPRITE_PIXELS) begin
      return 1'b0;
    end
    if (sy + SPRITE_PIXELS < fy || sy > fy + SPRITE_PIXELS) begin
      return 1'b0;
    end
    dx = sx - fx;
    if (dx <= -SPRITE_PIXELS || dx >= SPRITE_PIXELS) begin
      return 1'b0;
    end
    for (r = 0; r < SPRITE_PIXELS; r++) begin
      dy = sy - fy + r;
      if (dy >= 0 && dy < SPRITE_PIXELS) begin
        second_bits = 32'(mask_row(op.second_col, op.second_row, r));
        first_bits  = 32'(mask_row(op.first_col, op.first_row, dy));
        if (dx >= 0) begin
          first_bits = first_bits << dx;
        end else begin
          first_bits = first_bits >> (-dx);
        end
        if ((first_bits & second_bits) != 0) begin
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic sprite_op_t random_op();
    sprite_op_t op;
    op.action     = 1'($urandom);
    op.pixel_x    = 8'($urandom);
    op.pixel_y    = 8'($urandom);
    op.alpha      = 8'($urandom);
    op.first_x    = 16'($urandom);
    op.first_y    = 16'($urandom);
    op.first_col  = 4'($urandom);
    op.first_row  = 4'($urandom);
    op.second_x   = 16'($urandom);
    op.second_y   = 16'($urandom);
    op.second_col = 4'($urandom);
    op.second_row = 4'($urandom);
    return op;
  endfunction

  // Unused fields keep random values; the block has to ignore them.
  function automatic sprite_op_t load_op(int x, int y, int a);
    sprite_op_t op;
    op         = random_op();
    op.action  = ACTION_LOAD;
    op.pixel_x = 8'(x);
    op.pixel_y = 8'(y);
    op.alpha   = 8'(a);
    return op;
  endfunction

  function automatic sprite_op_t query_op(int fx, int fy, int fc, int fr,
                                          int sx, int sy, int sc, int sr);
    sprite_op_t op;
    op            = random_op();
    op.action     = ACTION_QUERY;
    op.first_x    = 16'(fx);
    op.first_y    = 16'(fy);
    op.first_col  = 4'(fc);
    op.first_row  = 4'(fr);
    op.second_x   = 16'(sx);
    op.second_y   = 16'(sy);
    op.second_col = 4'(sc);
    op.second_row = 4'(sr);
    return op;
  endfunction

  // Loads mostly into the busy cells, half of them near the threshold, and queries
  // mostly close together on busy cells; the rest is spread over the whole range.
  function automatic sprite_op_t random_sprite_op(logic force_query);
    sprite_op_t op;
    int         k, a;
    op = random_op();
    k  = $urandom_range(3);
    if (!force_query && $urandom_range(99) < 45) begin
      op.action = ACTION_LOAD;
      if ($urandom_range(99) < 65) begin
        op.pixel_x = {busy_col[k], 4'($urandom)};
        op.pixel_y = {busy_row[k], 4'($urandom)};
      end
      if ($urandom_range(1) == 0) begin
        a = int'(solid_threshold) + $urandom_range(4) - 2;
        a = (a < 0) ? 0 : ((a > 255) ? 255 : a);
        op.alpha = 8'(a);
      end
    end else begin
      op.action = ACTION_QUERY;
      if ($urandom_range(99) < 75) begin
        op.first_col = busy_col[k];
        op.first_row = busy_row[k];
        k = $urandom_range(3);
        op.second_col = busy_col[k];
        op.second_row = busy_row[k];
      end
      if ($urandom_range(99) < 75) begin
        op.second_x = 16'(int'(op.first_x) + $urandom_range(34) - 17);
        op.second_y = 16'(int'(op.first_y) + $urandom_range(34) - 17);
      end
    end
    return op;
  endfunction

  // Offers one transaction, with a random gap first, and records its effect
  // on the predicted state once the block has taken it.
  task automatic send_op(input sprite_op_t op);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= op.action;
    pixel_x_i    <= op.pixel_x;
    pixel_y_i    <= op.pixel_y;
    alpha_i      <= op.alpha;
    first_x_i    <= op.first_x;
    first_y_i    <= op.first_y;
    first_col_i  <= op.first_col;
    first_row_i  <= op.first_row;
    second_x_i   <= op.second_x;
    second_y_i   <= op.second_y;
    second_col_i <= op.second_col;
    second_row_i <= op.second_row;
    do @(posedge clk_i); while (!in_ready_o);
    if (op.action == ACTION_QUERY) begin
      hit_q.push_back(collision_hit(op));
    end else begin
      apply_load(op);
    end
  endtask

  // Stops offering and waits until every predicted hit has been seen, then
  // lets a trailing load finish.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // A setup and an access phase, then an idle phase on the bus.
  task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= THRESH_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_threshold();
    logic [APB_DATA_W-1:0] rdata;
    apb_access(1'b0, '0, rdata);
    if (rdata !== APB_DATA_W'(solid_threshold)) begin
      $error("alpha_threshold: expected %0d, got %0d", solid_threshold, rdata);
      fail_count++;
    end
  endtask

  task automatic set_threshold(input logic [ALPHA_W-1:0] value);
    logic [APB_DATA_W-1:0] rdata;
    apb_access(1'b1, APB_DATA_W'(value), rdata);
    solid_threshold = value;
    check_threshold();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset value of the threshold, then both extremes written and read back.
  task automatic test_threshold_register();
    check_threshold();
    set_threshold(8'd0);
    set_threshold(8'd255);
    set_threshold(THRESH_RESET);
  endtask

  // Threshold edges, sheet corners and each rejection rule of a query.
  task automatic test_directed();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_op(load_op(0, 0, 127));
    send_op(load_op(0, 0, 128));
    send_op(load_op(15, 15, 255));
    send_op(load_op(255, 255, 200));
    send_op(load_op(240, 240, 255));
    send_op(load_op(7, 8, 0));
    send_op(load_op(100, 37, 128));
    // Same cell on the same spot, and two cells with the same pattern.
    send_op(query_op(0, 0, 0, 0, 0, 0, 0, 0));
    send_op(query_op(100, 100, 0, 0, 100, 100, 15, 15));
    // Largest offsets still inside the box, one of them hitting.
    send_op(query_op(0, 0, 0, 0, 15, 0, 0, 0));
    send_op(query_op(0, 0, 0, 0, -15, -15, 0, 0));
    // Horizontal offset of a whole sprite width either way.
    send_op(query_op(0, 0, 0, 0, 16, 0, 0, 0));
    send_op(query_op(0, 0, 0, 0, -16, 0, 0, 0));
    // Boxes apart to the left, right, above and below.
    send_op(query_op(50, 50, 0, 0, 67, 50, 0, 0));
    send_op(query_op(50, 50, 0, 0, 33, 50, 0, 0));
    send_op(query_op(50, 50, 0, 0, 50, 67, 0, 0));
    send_op(query_op(50, 50, 0, 0, 50, 33, 0, 0));
    // Boxes touching vertically with no row in common.
    send_op(query_op(50, 50, 0, 0, 50, 66, 0, 0));
    // Position extremes.
    send_op(query_op(32767, 32767, 0, 0, -32768, -32768, 0, 0));
    send_op(query_op(-32768, -32768, 15, 15, -32768, -32768, 0, 0));
    send_op(query_op(32767, 32767, 0, 0, 32767, 32767, 15, 15));
    // Cell that was never loaded.
    send_op(query_op(0, 0, 3, 9, 0, 0, 3, 9));
    drain();
  endtask

  task automatic test_random_phase(input int count, input int src_pct, input int sink_pct,
                                   input logic [ALPHA_W-1:0] threshold);
    set_threshold(threshold);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    repeat (count) send_op(random_sprite_op(1'b0));
    drain();
  endtask

  // Receiver holds off while queries keep coming, so the block stalls its
  // input; the sender then waits for every hit before going on.
  task automatic test_output_stall();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_tgl <= ~hold_tgl;
    repeat (40) send_op(random_sprite_op(1'b1));
    drain();
  endtask

  initial begin
    int i;
    for (i = 0; i < 4; i++) begin
      busy_col[i] = 4'($urandom);
      busy_row[i] = 4'($urandom);
    end
    foreach (sheet_mask[r, c, k]) sheet_mask[r][c][k] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_threshold_register();
    test_directed();
    test_random_phase(230, 24, 80, 8'd255);
    test_random_phase(230, 80, 24, 8'($urandom_range(254, 1)));
    test_random_phase(230, 0, 0, 8'd0);
    test_output_stall();

    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: checks each output transaction and drives out_ready_i.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic expected;
    if (out_valid_o === 1'b1 && out_ready_i) begin
      if (hit_q.size() == 0) begin
        $error("hit: expected no transaction, got %0b", hit_o);
        fail_count++;
      end else begin
        expected = hit_q.pop_front();
        if (hit_o !== expected) begin
          $error("hit: expected %0b, got %0b", expected, hit_o);
          fail_count++;
        end
      end
    end
    if (hold_tgl != hold_seen) begin
      hold_seen   <= hold_tgl;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

endmodule
